// ===== rtl/core/ncp_pkg.sv =====
// Package for the normalized cross product block.
// Item types and fixed-point constants; no dependencies.
package ncp_pkg;

  localparam int FIELD_W     = 16;
  localparam int COMP_W_DEF  = 16;
  localparam int FRAC_BITS   = 14;
  localparam int OUT_W       = 16;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
  } ncp_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    degenerate;
  } ncp_out_t;

endpackage

// ===== rtl/core/normalized_cross_product_top.sv =====
// Normalized 3D cross product, fully pipelined, Q1.14 result.
// Depends on ncp_pkg (item types, constants).
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_ready | ncp_in_t  (two vectors)
//   out     | output    | out_valid/out_ready | ncp_out_t (unit vector, flag)
//
// One item per cycle sustained while out is ready. Stages in order:
// five product/square stages, one stage per root bit of the
// square-root pipe, one prep stage, one stage per quotient bit, output register.
// Reset (rst_n, sync) clears only the valid bits. A stall on out freezes every
// stage at once, so nothing is lost or repeated.
module normalized_cross_product_top #(
  parameter int COMPONENT_WIDTH = ncp_pkg::COMP_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ncp_pkg::ncp_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ncp_pkg::ncp_out_t out_data
);
  import ncp_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int SW = 4 * W;
  localparam int RW = 2 * W;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = MW + FRAC_BITS + 1;

  logic en;
  logic out_valid_r;
  ncp_out_t out_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // component extraction
  logic [FIELD_W-1:0] fld [6];
  logic signed [W-1:0] cmp [6];
  assign fld[0] = in_data.first_x;
  assign fld[1] = in_data.first_y;
  assign fld[2] = in_data.first_z;
  assign fld[3] = in_data.second_x;
  assign fld[4] = in_data.second_y;
  assign fld[5] = in_data.second_z;

  for (genvar i = 0; i < 6; i++) begin : g_cmp
    if (W <= FIELD_W) begin : g_narrow
      assign cmp[i] = fld[i][W-1:0];
    end else begin : g_wide
      assign cmp[i] = {{(W-FIELD_W){1'b0}}, fld[i]};
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p_r [6];
  logic v1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(cmp[1]) * PW'(cmp[5]);
      p_r[1] <= PW'(cmp[4]) * PW'(cmp[2]);
      p_r[2] <= PW'(cmp[2]) * PW'(cmp[3]);
      p_r[3] <= PW'(cmp[5]) * PW'(cmp[0]);
      p_r[4] <= PW'(cmp[0]) * PW'(cmp[4]);
      p_r[5] <= PW'(cmp[3]) * PW'(cmp[1]);
    end
  end

  // stage 2: cross, magnitude, sign
  logic [MW-1:0] m2_r [3];
  logic          n2_r [3];
  logic          v2_r;
  for (genvar l = 0; l < 3; l++) begin : g_s2
    logic signed [XW-1:0] cr;
    assign cr = XW'(p_r[2*l]) - XW'(p_r[2*l+1]);
    always_ff @(posedge clk) begin
      if (en) begin
        m2_r[l] <= cr[XW-1] ? MW'(-cr) : MW'(cr);
        n2_r[l] <= cr[XW-1];
      end
    end
  end

  // stage 3: partial squares
  logic [2*W-1:0] hh_r [3];
  logic [2*W-1:0] hl_r [3];
  logic [2*W-1:0] ll_r [3];
  logic [MW-1:0]  m3_r [3];
  logic           n3_r [3];
  logic           v3_r;
  for (genvar l = 0; l < 3; l++) begin : g_s3
    logic [W-1:0] mh, ml;
    assign mh = m2_r[l][MW-1:W];
    assign ml = m2_r[l][W-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        hh_r[l] <= (2*W)'(mh) * (2*W)'(mh);
        hl_r[l] <= (2*W)'(mh) * (2*W)'(ml);
        ll_r[l] <= (2*W)'(ml) * (2*W)'(ml);
        m3_r[l] <= m2_r[l];
        n3_r[l] <= n2_r[l];
      end
    end
  end

  // stage 4: squares
  logic [SW-1:0] sq4_r [3];
  logic [MW-1:0] m4_r  [3];
  logic          n4_r  [3];
  logic          v4_r;
  for (genvar l = 0; l < 3; l++) begin : g_s4
    always_ff @(posedge clk) begin
      if (en) begin
        sq4_r[l] <= (SW'(hh_r[l]) << (2*W)) + (SW'(hl_r[l]) << (W+1)) + SW'(ll_r[l]);
        m4_r[l]  <= m3_r[l];
        n4_r[l]  <= n3_r[l];
      end
    end
  end

  // stage 5 feeds the root pipe; index RW is its output
  logic [SW-1:0] sq_rem_r [RW+1];
  logic [RW-1:0] sq_res_r [RW+1];
  logic [MW-1:0] sq_m_r   [RW+1][3];
  logic          sq_n_r   [RW+1][3];
  logic          sq_dg_r  [RW+1];
  logic          sq_v_r   [RW+1];

  logic [SW-1:0] sum5;
  assign sum5 = sq4_r[0] + sq4_r[1] + sq4_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0] <= sum5;
      sq_res_r[0] <= '0;
      sq_dg_r[0]  <= (sum5 == '0);
      for (int l = 0; l < 3; l++) begin
        sq_m_r[0][l] <= m4_r[l];
        sq_n_r[0][l] <= n4_r[l];
      end
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [SW:0] d;
    logic        take;
    assign d    = ((SW+1)'(sq_res_r[k]) << (B+1)) + ((SW+1)'(1) << (2*B));
    assign take = d <= {1'b0, sq_rem_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1] <= take ? SW'({1'b0, sq_rem_r[k]} - d) : sq_rem_r[k];
        sq_res_r[k+1] <= take ? (sq_res_r[k] | (RW'(1) << B)) : sq_res_r[k];
        sq_dg_r[k+1]  <= sq_dg_r[k];
        for (int l = 0; l < 3; l++) begin
          sq_m_r[k+1][l] <= sq_m_r[k][l];
          sq_n_r[k+1][l] <= sq_n_r[k][l];
        end
      end
    end
  end

  // divide pipe; index QW is its output
  logic [NW-1:0] dv_rem_r [QW+1][3];
  logic [QW-1:0] dv_q_r   [QW+1][3];
  logic          dv_n_r   [QW+1][3];
  logic [RW-1:0] dv_d_r   [QW+1];
  logic          dv_dg_r  [QW+1];
  logic          dv_v_r   [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d_r[0]  <= sq_dg_r[RW] ? RW'(1) : sq_res_r[RW];
      dv_dg_r[0] <= sq_dg_r[RW];
      for (int l = 0; l < 3; l++) begin
        dv_rem_r[0][l] <= (NW'(sq_m_r[RW][l]) << FRAC_BITS) + NW'(sq_res_r[RW] >> 1);
        dv_q_r[0][l]   <= '0;
        dv_n_r[0][l]   <= sq_n_r[RW][l];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int I = QW - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dv_d_r[j]) << I;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_d_r[j+1]  <= dv_d_r[j];
        dv_dg_r[j+1] <= dv_dg_r[j];
        for (int l = 0; l < 3; l++) begin
          if (dsh <= dv_rem_r[j][l]) begin
            dv_rem_r[j+1][l] <= dv_rem_r[j][l] - dsh;
            dv_q_r[j+1][l]   <= dv_q_r[j][l] | (QW'(1) << I);
          end else begin
            dv_rem_r[j+1][l] <= dv_rem_r[j][l];
            dv_q_r[j+1][l]   <= dv_q_r[j][l];
          end
          dv_n_r[j+1][l] <= dv_n_r[j][l];
        end
      end
    end
  end

  // output register with sign restore
  logic [OUT_W-1:0] uq [3];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign uq[l] = dv_n_r[QW][l] ? OUT_W'(-OUT_W'(dv_q_r[QW][l])) : OUT_W'(dv_q_r[QW][l]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.unit_x     <= uq[0];
      out_r.unit_y     <= uq[1];
      out_r.unit_z     <= uq[2];
      out_r.degenerate <= dv_dg_r[QW];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= RW; k++) sq_v_r[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_v_r[j] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      sq_v_r[0] <= v4_r;
      for (int k = 0; k < RW; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[RW];
      for (int j = 0; j < QW; j++) dv_v_r[j+1] <= dv_v_r[j];
      out_valid_r <= dv_v_r[QW];
    end
  end

endmodule

// ===== dv/ncp_scoreboard.sv =====
// Scoreboard for the normalized cross product testbench.
// Predicts unit normals from accepted vector pairs; depends on ncp_pkg.
`timescale 1ns / 100ps

class ncp_scoreboard;
  ncp_pkg::ncp_out_t pending_normals[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Integer square root, floor; the squared length fits in 64 bits.
  function automatic logic [63:0] floor_root(logic [127:0] s);
    logic [63:0] root;
    logic [63:0] trial;
    logic [127:0] sq;
    root = 0;
    for (int b = 48; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      sq = 128'(trial) * 128'(trial);
      if (sq <= s) root = trial;
    end
    return root;
  endfunction

  function automatic logic [15:0] scale(logic signed [63:0] c, logic [63:0] len);
    logic [63:0] m;
    logic [63:0] q;
    m = c < 0 ? -c : c;
    q = ((m << 14) + (len >> 1)) / len;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic ncp_pkg::ncp_out_t unit_normal(ncp_pkg::ncp_in_t v);
    logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [63:0] mx, my, mz;
    logic [127:0] sum;
    logic [63:0] len;
    ncp_pkg::ncp_out_t r;
    ax = v.first_x; ay = v.first_y; az = v.first_z;
    bx = v.second_x; by = v.second_y; bz = v.second_z;
    cx = ay * bz - by * az;
    cy = az * bx - bz * ax;
    cz = ax * by - bx * ay;
    mx = cx < 0 ? -cx : cx;
    my = cy < 0 ? -cy : cy;
    mz = cz < 0 ? -cz : cz;
    sum = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
    r = '0;
    if (sum == 0) begin
      r.degenerate = 1'b1;
    end else begin
      len = floor_root(sum);
      r.unit_x = scale(cx, len);
      r.unit_y = scale(cy, len);
      r.unit_z = scale(cz, len);
    end
    return r;
  endfunction

  function void note_pair(ncp_pkg::ncp_in_t v);
    pending_normals.push_back(unit_normal(v));
  endfunction

  function void check_normal(ncp_pkg::ncp_out_t got);
    ncp_pkg::ncp_out_t exp;
    if (pending_normals.size() == 0) begin
      $display("%0t: unexpected item %h", $time, got);
      errors++;
      return;
    end
    exp = pending_normals.pop_front();
    if (got.unit_x !== exp.unit_x) begin
      $display("%0t: unit_x expected %0d got %0d", $time, exp.unit_x, got.unit_x);
      errors++;
    end
    if (got.unit_y !== exp.unit_y) begin
      $display("%0t: unit_y expected %0d got %0d", $time, exp.unit_y, got.unit_y);
      errors++;
    end
    if (got.unit_z !== exp.unit_z) begin
      $display("%0t: unit_z expected %0d got %0d", $time, exp.unit_z, got.unit_z);
      errors++;
    end
    if (got.degenerate !== exp.degenerate) begin
      $display("%0t: degenerate expected %b got %b", $time, exp.degenerate,
               got.degenerate);
      errors++;
    end
  endfunction
endclass

// ===== dv/tb.sv =====
// Top testbench for normalized_cross_product_top: directed and random vector
// pairs with random idling on both channels. Depends on ncp_pkg, ncp_scoreboard.
`timescale 1ns / 100ps

module tb;
  import ncp_pkg::*;

  localparam int LATENCY = 54;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ncp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ncp_out_t out_data;

  ncp_scoreboard sb = new();
  int cycles = 0;
  int rx_gap = 0;
  bit hold_out = 1'b0;

  normalized_cross_product_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("normalized_cross_product_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_pair(in_data);
    if (rst_n && out_valid && out_ready) sb.check_normal(out_data);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (hold_out) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_gap <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(ncp_in_t v, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(bit no_gap);
    ncp_in_t v;
    int k;
    v = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    k = $urandom_range(0, 9);
    if (k == 0) begin
      v.second_x = v.first_x; v.second_y = v.first_y; v.second_z = v.first_z;
    end else if (k == 1) begin
      v.second_x = -v.first_x; v.second_y = -v.first_y; v.second_z = -v.first_z;
    end
    send_pair(v, no_gap);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_normals.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair('0, 0);
    send_pair({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 0);
    send_pair({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 0);
    send_pair({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0}, 0);
    send_pair({16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0}, 0);
    send_pair({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}, 0);
    send_pair({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 0);
    send_pair({16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000}, 0);
    send_pair({16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000}, 0);
    send_pair({16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff}, 0);
    send_pair({16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0002, 16'h0003}, 0);
    send_pair({16'h1234, 16'h5678, 16'h9abc, 16'h1234, 16'h5678, 16'h9abc}, 0);
    send_pair({16'sd3, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0}, 0);
    send_pair({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, 0);
    drain();

    // Receiver stalls while the sender keeps pushing, until input backs up.
    hold_out = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
      for (n = 0; n < 120; n++) send_random(1);
    join
    drain();

    for (n = 0; n < 1650; n++) begin
      send_random($urandom_range(0, 4) != 0 || (n / 200) % 2 == 1);
      if (n == 800) drain();
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("normalized_cross_product_top regression: pass");
    end else begin
      $display("normalized_cross_product_top regression: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/ncp_pkg.sv
rtl/core/normalized_cross_product_top.sv
dv/ncp_scoreboard.sv
dv/tb.sv
